FILE: src/ffha_pkg.sv
// Package with the types, constants and state codes of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
	// Heap geometry. Sizes and addresses are kept in units of 8 bytes.
	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 24;
	localparam int GRAN_BYTES   = 8;
	localparam int UNITS        = HEAP_BYTES / GRAN_BYTES;
	localparam int IDX_W        = $clog2(UNITS);
	localparam int SZ_W         = IDX_W;
	localparam int ENTRY_W      = SZ_W + 1;
	localparam int HDR_U        = HEADER_BYTES / GRAN_BYTES;
	localparam int INIT_SIZE_U  = (HEAP_BYTES - HEADER_BYTES) / GRAN_BYTES;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2,
		OP_NONE   = 2'd3
	} op_kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] request_bytes;
		logic        pointer_present;
		logic [15:0] payload_offset;
	} cmd_t;

	typedef struct packed {
		logic        success;
		logic [15:0] result_offset;
		logic [16:0] copy_bytes;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_EV,
		ST_A_SPLIT,
		ST_F_RD,
		ST_F_EV,
		ST_F_NRD,
		ST_F_NEV,
		ST_DONE
	} ffha_state_t;
endpackage
`default_nettype wire

FILE: src/ffha_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read first port: one access per cycle, read data (the old contents) appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing of free blocks.
// A command is taken when start is high and busy is low; its result appears on rsp for
// exactly one cycle with done high, and the receiver cannot stall it. Block headers sit in
// one 8192 x 14 RAM indexed by header address in units of 8 bytes; an operation that walks
// the headers starts at offset 0 and handles each block with a RAM read, then an evaluate.
// A moving resize does a find, an allocate and a free walk in turn. After reset the INIT
// state writes the initial header before busy drops.
`default_nettype none
module first_fit_heap_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ffha_pkg::cmd_t cmd,
	output logic               done,
	output ffha_pkg::rsp_t     rsp
);
	import ffha_pkg::*;

	ffha_state_t state_q, state_d;

	logic [1:0]       kind_q;
	logic [23:0]      req_q;
	logic [15:0]      off_q;
	logic [SZ_W-1:0]  need_q;
	logic             big_q;
	logic [IDX_W:0]   addr_q;
	logic             prev_free_q;
	logic [IDX_W-1:0] prev_addr_q;
	logic [SZ_W-1:0]  prev_size_q;
	logic [IDX_W-1:0] t_addr_q;
	logic [SZ_W-1:0]  t_size_q;
	logic [IDX_W:0]   naddr_q;
	logic [SZ_W-1:0]  old_q;
	logic             rz_find_q;
	logic             mv_q;
	logic             ok_q;
	logic [15:0]      res_q;
	logic [16:0]      copy_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(UNITS)) u_hdr_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Decode of the header just read and of the incoming command.
	logic [SZ_W-1:0] rd_size;
	logic            rd_free;
	logic [IDX_W:0]  next_addr;
	logic            at_end;
	logic            fit;
	logic            split;
	logic            hit;
	logic [21:0]     need_w;
	logic            acc;
	logic            alloc_path;
	logic            free_path;
	logic            nfree;
	logic [IDX_W:0]  tsz;
	logic [IDX_W:0]  psz;

	assign rd_size    = ram_rdata[ENTRY_W-1:1];
	assign rd_free    = ram_rdata[0];
	assign next_addr  = addr_q + (IDX_W+1)'(HDR_U) + {1'b0, rd_size};
	assign at_end     = addr_q[IDX_W];
	assign fit        = rd_free && (rd_size >= need_q);
	assign split      = {1'b0, rd_size} >= ({1'b0, need_q} + (IDX_W+1)'(HDR_U + 1));
	assign hit        = (off_q[2:0] == 3'd0) &&
		({1'b0, off_q[15:3]} == addr_q + (IDX_W+1)'(HDR_U));
	assign need_w     = 22'(({1'b0, cmd.request_bytes} + 25'd7) >> 3);
	assign acc        = start && !busy;
	assign alloc_path = (cmd.kind == OP_ALLOC) ||
		(cmd.kind == OP_RESIZE && !cmd.pointer_present);
	assign free_path  = (cmd.kind == OP_FREE) ||
		(cmd.kind == OP_RESIZE && cmd.request_bytes == 24'd0);
	assign nfree      = !naddr_q[IDX_W] && rd_free;
	assign tsz        = {1'b0, t_size_q} +
		(nfree ? ({1'b0, rd_size} + (IDX_W+1)'(HDR_U)) : '0);
	assign psz        = {1'b0, prev_size_q} + (IDX_W+1)'(HDR_U) + tsz;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = addr_q[IDX_W-1:0];
		ram_wdata = '0;
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = '0;
				ram_wdata = {SZ_W'(INIT_SIZE_U), 1'b1};
				state_d   = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					if (cmd.kind == OP_NONE) begin
						state_d = ST_DONE;
					end else if (alloc_path) begin
						if (cmd.request_bytes == 24'd0 || need_w > 22'(INIT_SIZE_U)) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_A_RD;
						end
					end else if (free_path && !cmd.pointer_present) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_F_RD;
					end
				end
			end
			ST_A_RD: begin
				state_d = at_end ? ST_DONE : ST_A_EV;
			end
			ST_A_EV: begin
				if (fit) begin
					ram_we    = 1'b1;
					ram_wdata = {(split ? need_q : rd_size), 1'b0};
					if (split) begin
						state_d = ST_A_SPLIT;
					end else begin
						state_d = mv_q ? ST_F_RD : ST_DONE;
					end
				end else begin
					state_d = ST_A_RD;
				end
			end
			ST_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_addr  = naddr_q[IDX_W-1:0];
				ram_wdata = {t_size_q, 1'b1};
				state_d   = mv_q ? ST_F_RD : ST_DONE;
			end
			ST_F_RD: begin
				state_d = at_end ? ST_DONE : ST_F_EV;
			end
			ST_F_EV: begin
				if (hit) begin
					if (!rz_find_q) begin
						state_d = ST_F_NRD;
					end else if (rd_free) begin
						state_d = ST_DONE;
					end else if ({rd_size, 3'b000} >= req_q[15:0] && req_q[23:16] == 8'd0) begin
						state_d = ST_DONE;
					end else if (big_q) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_A_RD;
					end
				end else begin
					state_d = ST_F_RD;
				end
			end
			ST_F_NRD: begin
				ram_addr = naddr_q[IDX_W-1:0];
				state_d  = ST_F_NEV;
			end
			ST_F_NEV: begin
				ram_we = 1'b1;
				if (prev_free_q) begin
					ram_addr  = prev_addr_q;
					ram_wdata = {psz[SZ_W-1:0], 1'b1};
				end else begin
					ram_addr  = t_addr_q;
					ram_wdata = {tsz[SZ_W-1:0], 1'b1};
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk registers and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					kind_q      <= cmd.kind;
					req_q       <= cmd.request_bytes;
					off_q       <= cmd.payload_offset;
					need_q      <= need_w[SZ_W-1:0];
					big_q       <= need_w > 22'(INIT_SIZE_U);
					addr_q      <= '0;
					prev_free_q <= 1'b0;
					mv_q        <= 1'b0;
					rz_find_q   <= !alloc_path && !free_path;
					res_q       <= '0;
					copy_q      <= '0;
					ok_q        <= cmd.kind == OP_FREE && !cmd.pointer_present;
				end
			end
			ST_A_EV: begin
				if (fit) begin
					ok_q     <= 1'b1;
					res_q    <= {addr_q[IDX_W-1:0] + IDX_W'(HDR_U), 3'b000};
					naddr_q  <= addr_q + (IDX_W+1)'(HDR_U) + {1'b0, need_q};
					t_size_q <= rd_size - need_q - SZ_W'(HDR_U);
					if (mv_q) begin
						copy_q      <= {1'b0, old_q, 3'b000};
						addr_q      <= '0;
						prev_free_q <= 1'b0;
					end
				end else begin
					addr_q <= next_addr;
				end
			end
			ST_F_EV: begin
				if (hit) begin
					if (!rz_find_q) begin
						t_addr_q <= addr_q[IDX_W-1:0];
						t_size_q <= rd_size;
						naddr_q  <= next_addr;
						// A plain free succeeds once its block is found.
						if (kind_q == OP_FREE) begin
							ok_q <= 1'b1;
						end
					end else if (!rd_free) begin
						if ({rd_size, 3'b000} >= req_q[15:0] && req_q[23:16] == 8'd0) begin
							ok_q  <= 1'b1;
							res_q <= off_q;
						end else begin
							old_q     <= rd_size;
							mv_q      <= 1'b1;
							rz_find_q <= 1'b0;
							addr_q    <= '0;
						end
					end
				end else begin
					prev_free_q <= rd_free;
					prev_addr_q <= addr_q[IDX_W-1:0];
					prev_size_q <= rd_size;
					addr_q      <= next_addr;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.success       = ok_q;
	assign rsp.result_offset = res_q;
	assign rsp.copy_bytes    = copy_q;
endmodule
`default_nettype wire
